[rtl/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

  // One input beat: hue in degrees, saturation and value in percent, alpha.
  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
    logic [7:0] alpha_in;
  } hsv_in_t;

  // One output beat: 8-bit color channels and alpha.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
  } rgb_out_t;

  localparam int unsigned PctWidth   = 7;
  localparam int unsigned RemWidth   = 6;
  localparam int unsigned CoefWidth  = 13;   // coefficients up to 6000
  localparam int unsigned ProdWidth  = 20;   // percent * coefficient, up to 600000
  localparam int unsigned ChanWidth  = 8;

  localparam logic [8:0]           HueWrap    = 9'd360;
  localparam logic [8:0]           SectorDeg  = 9'd60;
  localparam logic [PctWidth-1:0]  PctMax     = 7'd100;
  localparam logic [CoefWidth-1:0] CoefFull   = 13'd6000;
  localparam logic [7:0]           AlphaOpaque = 8'hFF;

  // channel = floor(255 * x / 600000) = floor(17 * x / 40000)
  // 40000 = 64 * 625; divide by 625 as multiply by ceil(2^28 / 625) and shift.
  localparam int unsigned ScaledWidth = 24;  // 17 * x, below 2^24
  localparam int unsigned PreShift    = 6;
  localparam int unsigned QuotWidth   = ScaledWidth - PreShift;
  localparam int unsigned RecipWidth  = 19;
  localparam logic [RecipWidth-1:0] ChanRecip = 19'd429497;
  localparam int unsigned ChanShift   = 28;

endpackage

[rtl/hsv2rgb_scale.sv]
module hsv2rgb_scale (
  input  logic                                clk_i,
  input  logic                                mul_en_i,
  input  logic                                div_en_i,
  input  logic [hsv2rgb_pkg::PctWidth-1:0]    pct_i,
  input  logic [hsv2rgb_pkg::CoefWidth-1:0]   coef_i,
  output logic [hsv2rgb_pkg::ChanWidth-1:0]   chan_o
);

  localparam int unsigned MulWidth = hsv2rgb_pkg::QuotWidth + hsv2rgb_pkg::RecipWidth;

  logic [hsv2rgb_pkg::ProdWidth-1:0]   prod_d, prod_q;
  logic [hsv2rgb_pkg::ScaledWidth-1:0] scaled;
  logic [hsv2rgb_pkg::QuotWidth-1:0]   pre_div;
  logic [MulWidth-1:0]                 recip_prod;
  logic [hsv2rgb_pkg::ChanWidth-1:0]   chan_d, chan_q;

  // Value times the sector coefficient.
  assign prod_d = hsv2rgb_pkg::ProdWidth'(pct_i) * hsv2rgb_pkg::ProdWidth'(coef_i);

  // Times 17 by shift-add, drop the power-of-two part of 40000, divide by 625.
  assign scaled  = (hsv2rgb_pkg::ScaledWidth'(prod_q) << 4)
                 + hsv2rgb_pkg::ScaledWidth'(prod_q);
  assign pre_div = scaled[hsv2rgb_pkg::ScaledWidth-1:hsv2rgb_pkg::PreShift];
  assign recip_prod = MulWidth'(pre_div) * MulWidth'(hsv2rgb_pkg::ChanRecip);
  assign chan_d = recip_prod[hsv2rgb_pkg::ChanShift +: hsv2rgb_pkg::ChanWidth];

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
    if (div_en_i) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

[rtl/hsv_to_rgb_converter_top.sv]
// HSV to RGB converter, four register stages.
// Throughput: one beat per cycle while the output is not stalled; each stage holds only while its successor is full.
// Reset (rst_ni low, asynchronous): all stage valid bits clear, pipeline empties.
// Payload registers are not reset.
module hsv_to_rgb_converter_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hsv2rgb_pkg::hsv_in_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hsv2rgb_pkg::rgb_out_t out_data_o
);

  // Hue sectors, 60 degrees each.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  localparam int unsigned PW = hsv2rgb_pkg::PctWidth;
  localparam int unsigned CW = hsv2rgb_pkg::CoefWidth;
  localparam int unsigned RW = hsv2rgb_pkg::RemWidth;

  // ---------------------------------------------------------------------------
  // Flow control. A stage loads when it is empty or its successor loads, so
  // bubbles collapse and a full output register still lets the front fill.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, vo_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !vo_q || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_stall_o  = !adv1;
  assign out_valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) vo_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: clamp percentages, fold hue into 0..359, split into sector/rem.
  // Zero saturation forces opaque alpha; the channel math already gives grey
  // there, since every coefficient collapses to full scale.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] sat_c, val_c;
  logic [8:0]    hue_w;
  sector_e       sector_d;
  logic [8:0]    rem_w;
  logic [7:0]    alpha_d;

  sector_e       sector1_q;
  logic [RW-1:0] rem1_q;
  logic [PW-1:0] sat1_q, val1_q;
  logic [7:0]    alpha1_q;

  always_comb begin
    sat_c = (in_data_i.saturation > hsv2rgb_pkg::PctMax) ? hsv2rgb_pkg::PctMax
                                                         : in_data_i.saturation;
    val_c = (in_data_i.brightness > hsv2rgb_pkg::PctMax) ? hsv2rgb_pkg::PctMax
                                                         : in_data_i.brightness;
    hue_w = (in_data_i.hue >= hsv2rgb_pkg::HueWrap) ? in_data_i.hue - hsv2rgb_pkg::HueWrap
                                                    : in_data_i.hue;
    alpha_d = (in_data_i.saturation == '0) ? hsv2rgb_pkg::AlphaOpaque : in_data_i.alpha_in;

    if (hue_w < hsv2rgb_pkg::SectorDeg) begin
      sector_d = SEC_RED_YEL;
      rem_w    = hue_w;
    end else if (hue_w < 9'(2 * hsv2rgb_pkg::SectorDeg)) begin
      sector_d = SEC_YEL_GRN;
      rem_w    = hue_w - hsv2rgb_pkg::SectorDeg;
    end else if (hue_w < 9'(3 * hsv2rgb_pkg::SectorDeg)) begin
      sector_d = SEC_GRN_CYN;
      rem_w    = hue_w - 9'(2 * hsv2rgb_pkg::SectorDeg);
    end else if (hue_w < 9'(4 * hsv2rgb_pkg::SectorDeg)) begin
      sector_d = SEC_CYN_BLU;
      rem_w    = hue_w - 9'(3 * hsv2rgb_pkg::SectorDeg);
    end else if (hue_w < 9'(5 * hsv2rgb_pkg::SectorDeg)) begin
      sector_d = SEC_BLU_MAG;
      rem_w    = hue_w - 9'(4 * hsv2rgb_pkg::SectorDeg);
    end else begin
      sector_d = SEC_MAG_RED;
      rem_w    = hue_w - 9'(5 * hsv2rgb_pkg::SectorDeg);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      sector1_q <= sector_d;
      rem1_q    <= rem_w[RW-1:0];
      sat1_q    <= sat_c;
      val1_q    <= val_c;
      alpha1_q  <= alpha_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: coefficients on a 6000 scale and the sector permutation.
  //   p = (100-S)*60, q = 6000 - rem*S, t = 6000 - (60-rem)*S
  // ---------------------------------------------------------------------------
  logic [CW-1:0] rem_sat, comp_sat, coef_p, coef_q, coef_t;
  logic [6:0]    rem_comp;
  logic [CW-1:0] kr_d, kg_d, kb_d;

  logic [CW-1:0] kr2_q, kg2_q, kb2_q;
  logic [PW-1:0] val2_q;
  logic [7:0]    alpha2_q;

  always_comb begin
    rem_comp = 7'(hsv2rgb_pkg::SectorDeg) - 7'(rem1_q);
    rem_sat  = CW'(rem1_q) * CW'(sat1_q);
    comp_sat = CW'(rem_comp) * CW'(sat1_q);
    coef_p   = CW'(hsv2rgb_pkg::PctMax - sat1_q) * CW'(hsv2rgb_pkg::SectorDeg);
    coef_q   = hsv2rgb_pkg::CoefFull - rem_sat;
    coef_t   = hsv2rgb_pkg::CoefFull - comp_sat;

    case (sector1_q)
      SEC_RED_YEL: begin
        kr_d = hsv2rgb_pkg::CoefFull; kg_d = coef_t; kb_d = coef_p;
      end
      SEC_YEL_GRN: begin
        kr_d = coef_q; kg_d = hsv2rgb_pkg::CoefFull; kb_d = coef_p;
      end
      SEC_GRN_CYN: begin
        kr_d = coef_p; kg_d = hsv2rgb_pkg::CoefFull; kb_d = coef_t;
      end
      SEC_CYN_BLU: begin
        kr_d = coef_p; kg_d = coef_q; kb_d = hsv2rgb_pkg::CoefFull;
      end
      SEC_BLU_MAG: begin
        kr_d = coef_t; kg_d = coef_p; kb_d = hsv2rgb_pkg::CoefFull;
      end
      default: begin
        kr_d = hsv2rgb_pkg::CoefFull; kg_d = coef_p; kb_d = coef_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      kr2_q    <= kr_d;
      kg2_q    <= kg_d;
      kb2_q    <= kb_d;
      val2_q   <= val1_q;
      alpha2_q <= alpha1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3 and 4: per channel, value times coefficient, then the scale to
  // 8 bits. Alpha rides alongside.
  // ---------------------------------------------------------------------------
  logic [7:0] alpha3_q, alpha4_q;
  logic [hsv2rgb_pkg::ChanWidth-1:0] red, green, blue;

  hsv2rgb_scale u_scale_red (
    .clk_i    (clk_i),
    .mul_en_i (adv3),
    .div_en_i (adv4),
    .pct_i    (val2_q),
    .coef_i   (kr2_q),
    .chan_o   (red)
  );

  hsv2rgb_scale u_scale_green (
    .clk_i    (clk_i),
    .mul_en_i (adv3),
    .div_en_i (adv4),
    .pct_i    (val2_q),
    .coef_i   (kg2_q),
    .chan_o   (green)
  );

  hsv2rgb_scale u_scale_blue (
    .clk_i    (clk_i),
    .mul_en_i (adv3),
    .div_en_i (adv4),
    .pct_i    (val2_q),
    .coef_i   (kb2_q),
    .chan_o   (blue)
  );

  always_ff @(posedge clk_i) begin
    if (adv3) alpha3_q <= alpha2_q;
    if (adv4) alpha4_q <= alpha3_q;
  end

  assign out_data_o.red       = red;
  assign out_data_o.green     = green;
  assign out_data_o.blue      = blue;
  assign out_data_o.alpha_out = alpha4_q;

endmodule

[rtl/hsv2rgb_checker.sv]
module hsv2rgb_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input hsv2rgb_pkg::hsv_in_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input hsv2rgb_pkg::rgb_out_t out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // Hold a stalled output beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat dropped or changed");

  // Back-pressure reaches the input only when the output is full and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  // An accepted beat reaches the output if the output is not stalled while it passes the stages.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("output beat missing after pipeline latency");

  // Zero saturation yields opaque grey.
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_data_i.saturation == '0
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_data_o.alpha_out == 8'hFF && out_data_o.red == out_data_o.green
        && out_data_o.green == out_data_o.blue)
    else $error("zero saturation did not give opaque grey");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
